[design/fdt_pkg.sv]
// fdt_pkg: shared widths, command and status codes, register indexes and
// structs for the fan duty controller; no dependencies
package fdt_pkg;

    // fixed field widths
    localparam int CMD_W     = 3;
    localparam int CH_W      = 3;
    localparam int VALUE_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int DUTY_W    = 8;
    localparam int SLOT_W    = 8;
    localparam int SLOTS     = 6;
    localparam int PACKED_W  = SLOT_W * SLOTS;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = PACKED_W;

    // module parameter defaults
    localparam int CHANNELS_DEF  = 6;
    localparam int TEMP_BITS_DEF = 8;

    // divider: 16-bit numerator, 8-bit divisor, one quotient bit per cycle
    localparam int DIV_NUM_W = 2 * SLOT_W;
    localparam int DIV_DEN_W = SLOT_W;

    localparam logic [DUTY_W-1:0] FULL_DUTY = 8'd255;

    // commands
    localparam logic [CMD_W-1:0] CMD_SET_TEMP = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_DUTY = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_LOAD = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_RPM  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DISABLED = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY = 2'd3;

    // configuration reset values
    localparam logic [SLOTS-1:0]    ENABLED_RST  = '1;
    localparam logic [PACKED_W-1:0] LOW_RST      = '0;
    localparam logic [PACKED_W-1:0] HIGH_RST     = '1;
    localparam logic [PACKED_W-1:0] MIN_DUTY_RST = '0;

    // per-channel view of the configuration
    typedef struct packed {
        logic              enabled;
        logic [SLOT_W-1:0] low;
        logic [SLOT_W-1:0] high;
        logic [SLOT_W-1:0] min_duty;
    } t_chan_cfg;

    // divider status toward the controller
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DUTY_W-1:0] quot;
    } t_div_stat;

endpackage

[design/fdt_if.sv]
// fdt_if: valid/ready channel interfaces for command, result and
// configuration words; depends on fdt_pkg
interface fdt_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [fdt_pkg::CMD_W-1:0]     cmd;
    logic [fdt_pkg::CH_W-1:0]      channel;
    logic [fdt_pkg::VALUE_W-1:0]   value;

    modport source (output valid, cmd, channel, value, input ready);
    modport sink   (input valid, cmd, channel, value, output ready);
endinterface

interface fdt_res_if;
    logic                          valid;
    logic                          ready;
    logic [fdt_pkg::STATUS_W-1:0]  status;
    logic                          pwm_write;
    logic [fdt_pkg::CH_W-1:0]      out_channel;
    logic [fdt_pkg::DUTY_W-1:0]    out_duty;
    logic [7:0]                    read_temp;
    logic [fdt_pkg::VALUE_W-1:0]   read_load;
    logic [fdt_pkg::VALUE_W-1:0]   read_rpm;

    modport source (output valid, status, pwm_write, out_channel, out_duty,
                    read_temp, read_load, read_rpm, input ready);
    modport sink   (input valid, status, pwm_write, out_channel, out_duty,
                    read_temp, read_load, read_rpm, output ready);
endinterface

interface fdt_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fdt_pkg::CFG_IDX_W-1:0]  index;
    logic [fdt_pkg::CFG_DAT_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/fdt_cfg.sv]
// fdt_cfg: configuration registers and per-channel threshold selection
// depends on fdt_pkg and fdt_cfg_if
module fdt_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    fdt_cfg_if.sink                   i_cfg,
    input  logic [fdt_pkg::CH_W-1:0]  i_ch,
    output fdt_pkg::t_chan_cfg        o_chan_cfg
);

    logic [fdt_pkg::SLOTS-1:0]    r_enabled;
    logic [fdt_pkg::PACKED_W-1:0] r_low;
    logic [fdt_pkg::PACKED_W-1:0] r_high;
    logic [fdt_pkg::PACKED_W-1:0] r_min_duty;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= fdt_pkg::ENABLED_RST;
            r_low      <= fdt_pkg::LOW_RST;
            r_high     <= fdt_pkg::HIGH_RST;
            r_min_duty <= fdt_pkg::MIN_DUTY_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                fdt_pkg::REG_ENABLED:  r_enabled  <= i_cfg.data[fdt_pkg::SLOTS-1:0];
                fdt_pkg::REG_LOW:      r_low      <= i_cfg.data;
                fdt_pkg::REG_HIGH:     r_high     <= i_cfg.data;
                fdt_pkg::REG_MIN_DUTY: r_min_duty <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // slot select; channels without a slot read as disabled with zero fields
    always_comb begin
        o_chan_cfg = '0;
        for (int s = 0; s < fdt_pkg::SLOTS; s++) begin
            if (i_ch == fdt_pkg::CH_W'(s)) begin
                o_chan_cfg.enabled  = r_enabled[s];
                o_chan_cfg.low      = r_low[s*fdt_pkg::SLOT_W +: fdt_pkg::SLOT_W];
                o_chan_cfg.high     = r_high[s*fdt_pkg::SLOT_W +: fdt_pkg::SLOT_W];
                o_chan_cfg.min_duty = r_min_duty[s*fdt_pkg::SLOT_W +: fdt_pkg::SLOT_W];
            end
        end
    end

endmodule

[design/fdt_div.sv]
// fdt_div: bit-serial restoring divider, one quotient bit per cycle
// depends on fdt_pkg
module fdt_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [fdt_pkg::DIV_NUM_W-1:0]  i_numer,
    input  logic [fdt_pkg::DIV_DEN_W-1:0]  i_denom,
    output fdt_pkg::t_div_stat             o_stat
);

    localparam int NUM_W = fdt_pkg::DIV_NUM_W;
    localparam int DEN_W = fdt_pkg::DIV_DEN_W;
    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;   // numerator bits shift out, quotient bits shift in
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             q_bit;
    logic [DEN_W-1:0] n_rem;
    logic             last_step;

    assign trial     = {r_rem, r_num[NUM_W-1]};
    assign diff      = trial - {1'b0, r_den};
    assign q_bit     = (trial >= {1'b0, r_den});
    // remainder stays below the divisor, so it fits the divisor width
    assign n_rem     = q_bit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    assign last_step = (r_cnt == CNT_W'(NUM_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_numer;
            r_den <= i_denom;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.quot = r_num[fdt_pkg::DUTY_W-1:0];

endmodule

[design/fan_duty_from_temperature.sv]
// fan_duty_from_temperature: multi-channel linear fan curve controller, top level
// depends on fdt_pkg, fdt_if, fdt_cfg and fdt_div
//
//  channel   dir  words carried
//  i_cmd     in   cmd, channel, value
//  o_res     out  status, pwm_write, out_channel, out_duty, read_temp/load/rpm
//  i_cfg     in   index, data (one configuration register per word)
//
// one command word at a time: each word passes S_EVAL and S_DONE from accept to result;
// a temperature word in the linear region also passes S_DIV, where the bit-serial
// divider forms offset*255/range one quotient bit per cycle
// i_rst_n is synchronous; it restores the register defaults and per-channel
// state (duty 255, everything else 0)
// a result waits in the output register while the next word is taken in;
// the controller stalls only when that register is still full
module fan_duty_from_temperature #(
    parameter int CHANNELS  = fdt_pkg::CHANNELS_DEF,
    parameter int TEMP_BITS = fdt_pkg::TEMP_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    fdt_cmd_if.sink  i_cmd,
    fdt_res_if.source o_res,
    fdt_cfg_if.sink  i_cfg
);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W    = (TEMP_BITS > fdt_pkg::SLOT_W) ? TEMP_BITS : fdt_pkg::SLOT_W;
    localparam int DUTY_W   = fdt_pkg::DUTY_W;
    localparam int VALUE_W  = fdt_pkg::VALUE_W;

    // controller states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // accepted command word
    logic [fdt_pkg::CMD_W-1:0] r_cmd;
    logic [fdt_pkg::CH_W-1:0]  r_ch;
    logic [VALUE_W-1:0]        r_val;

    // new duty for a temperature word
    logic [DUTY_W-1:0] r_nd;
    logic [DUTY_W-1:0] n_nd;

    // per-channel state
    logic [TEMP_BITS-1:0] r_temp [CHANNELS];
    logic [DUTY_W-1:0]    r_duty [CHANNELS];
    logic [VALUE_W-1:0]   r_load [CHANNELS];
    logic [VALUE_W-1:0]   r_rpm  [CHANNELS];

    // output register
    logic                           r_out_valid;
    logic [fdt_pkg::STATUS_W-1:0]   r_out_status;
    logic                           r_out_pwm;
    logic [fdt_pkg::CH_W-1:0]       r_out_ch;
    logic [DUTY_W-1:0]              r_out_duty;
    logic [7:0]                     r_out_temp;
    logic [VALUE_W-1:0]             r_out_load;
    logic [VALUE_W-1:0]             r_out_rpm;

    fdt_pkg::t_chan_cfg chan_cfg;
    fdt_pkg::t_div_stat div_stat;

    logic                         accept;
    logic                         out_free;
    logic                         finish;
    logic [CH_IDX_W-1:0]          ch_idx;
    logic                         ch_ok;
    logic [fdt_pkg::STATUS_W-1:0] status;

    // curve evaluation
    logic [TEMP_BITS-1:0]         temp_in;
    logic [CMP_W-1:0]             temp_w;
    logic [CMP_W-1:0]             low_w;
    logic [CMP_W-1:0]             high_w;
    logic [CMP_W-1:0]             offset_w;
    logic [DUTY_W-1:0]            offset;
    logic [fdt_pkg::SLOT_W-1:0]   span;
    logic [fdt_pkg::DIV_NUM_W-1:0] numer;
    logic                         div_start;

    // result fields
    logic                   res_pwm;
    logic [DUTY_W-1:0]      res_duty;
    logic [7:0]             res_temp;
    logic [VALUE_W-1:0]     res_load;
    logic [VALUE_W-1:0]     res_rpm;
    logic [CMP_W-1:0]       stored_temp_w;
    logic [DUTY_W-1:0]      cur_duty;

    fdt_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (i_cfg),
        .i_ch       (r_ch),
        .o_chan_cfg (chan_cfg)
    );

    fdt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_numer (numer),
        .i_denom (span),
        .o_stat  (div_stat)
    );

    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || o_res.ready;
    assign finish      = (r_state == S_DONE) && out_free;

    // channel checks; channels >= CHANNELS report range, others need their enable bit
    assign ch_idx = r_ch[CH_IDX_W-1:0];
    always_comb begin
        if ({1'b0, r_ch} >= (fdt_pkg::CH_W + 1)'(CHANNELS)) begin
            status = fdt_pkg::ST_RANGE;
        end else if (!chan_cfg.enabled) begin
            status = fdt_pkg::ST_DISABLED;
        end else begin
            status = fdt_pkg::ST_OK;
        end
    end
    assign ch_ok = (status == fdt_pkg::ST_OK);

    // linear curve front end: thresholds, offset and scaled numerator
    assign temp_in  = r_val[TEMP_BITS-1:0];
    assign temp_w   = CMP_W'(temp_in);
    assign low_w    = CMP_W'(chan_cfg.low);
    assign high_w   = CMP_W'(chan_cfg.high);
    assign offset_w = temp_w - low_w;
    // inside the linear region temp <= high <= 255, so the offset fits a byte
    assign offset   = offset_w[DUTY_W-1:0];
    assign span     = chan_cfg.high - chan_cfg.low;
    // offset * 255 as (offset << 8) - offset
    assign numer    = {offset, 8'd0} - {8'd0, offset};

    always_comb begin
        n_state   = r_state;
        n_nd      = r_nd;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_DONE;
                if (ch_ok && r_cmd == fdt_pkg::CMD_SET_TEMP) begin
                    priority if (temp_in == '0) begin
                        n_nd = fdt_pkg::FULL_DUTY;       // missing reading forces full duty
                    end else if (temp_w < low_w) begin
                        n_nd = '0;
                    end else if (temp_w > high_w) begin
                        n_nd = fdt_pkg::FULL_DUTY;
                    end else if (span == '0) begin
                        n_nd = fdt_pkg::FULL_DUTY;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    // clamp to the channel's minimum duty
                    n_nd    = (div_stat.quot < chan_cfg.min_duty) ? chan_cfg.min_duty
                                                                  : div_stat.quot;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd.cmd;
            r_ch  <= i_cmd.channel;
            r_val <= i_cmd.value;
        end
        r_nd <= n_nd;
    end

    // result word for the finishing command
    assign cur_duty      = r_duty[ch_idx];
    assign stored_temp_w = CMP_W'(r_temp[ch_idx]);
    always_comb begin
        res_pwm  = 1'b0;
        res_duty = '0;
        res_temp = '0;
        res_load = '0;
        res_rpm  = '0;
        if (ch_ok) begin
            res_duty = cur_duty;
            unique case (r_cmd)
                fdt_pkg::CMD_SET_TEMP: begin
                    res_pwm  = (r_nd != cur_duty);
                    res_duty = r_nd;
                end
                fdt_pkg::CMD_SET_DUTY: begin
                    res_pwm  = 1'b1;
                    res_duty = r_val[DUTY_W-1:0];
                end
                fdt_pkg::CMD_READ: begin
                    res_temp = stored_temp_w[7:0];
                    res_load = r_load[ch_idx];
                    res_rpm  = r_rpm[ch_idx];
                end
                default: ;   // load, rpm and unknown commands leave the duty alone
            endcase
        end
    end

    // per-channel state update as the result is handed on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_temp[c] <= '0;
                r_duty[c] <= fdt_pkg::FULL_DUTY;
                r_load[c] <= '0;
                r_rpm[c]  <= '0;
            end
        end else if (finish && ch_ok) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (ch_idx == CH_IDX_W'(c)) begin
                    unique case (r_cmd)
                        fdt_pkg::CMD_SET_TEMP: begin
                            r_temp[c] <= temp_in;
                            r_duty[c] <= r_nd;
                        end
                        fdt_pkg::CMD_SET_DUTY: r_duty[c] <= r_val[DUTY_W-1:0];
                        fdt_pkg::CMD_SET_LOAD: r_load[c] <= r_val;
                        fdt_pkg::CMD_SET_RPM:  r_rpm[c]  <= r_val;
                        default: ;
                    endcase
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_status <= status;
            r_out_pwm    <= res_pwm;
            r_out_ch     <= r_ch;
            r_out_duty   <= res_duty;
            r_out_temp   <= res_temp;
            r_out_load   <= res_load;
            r_out_rpm    <= res_rpm;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.pwm_write   = r_out_pwm;
    assign o_res.out_channel = r_out_ch;
    assign o_res.out_duty    = r_out_duty;
    assign o_res.read_temp   = r_out_temp;
    assign o_res.read_load   = r_out_load;
    assign o_res.read_rpm    = r_out_rpm;

`ifndef ASSERT_OFF
    // the divider reports completion only while the controller waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("divider done outside divide state");

    // the divider is idle whenever a new command word is taken in
    a_div_idle_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !div_stat.busy)
        else $error("command accepted while divider busy");

    // a new result only ever comes from the finishing state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside finishing state");

    // rejected words never push a duty or report one
    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != fdt_pkg::ST_OK)
            |-> (!r_out_pwm && r_out_duty == '0))
        else $error("rejected word carries a duty");
`endif

endmodule
